@@ sv/assert_macros.svh @@
// assertion helpers used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/mch_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_pkg
// shared types and constants of the midi channel message handler
// ----------------------------------------------------------------------------
package mch_pkg;

   localparam int NOTE_COUNT          = 128;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [4:0] {
      CMD_NOTEON   = 5'd0,
      CMD_NOTEOFF  = 5'd1,
      CMD_RELEASE  = 5'd2,
      CMD_ALLOFF   = 5'd3,
      CMD_MOD      = 5'd4,
      CMD_EXPR     = 5'd5,
      CMD_AFTER    = 5'd6,
      CMD_BEND     = 5'd7,
      CMD_VOL      = 5'd8,
      CMD_PAN      = 5'd9,
      CMD_SENDS    = 5'd10,
      CMD_PSWITCH  = 5'd11,
      CMD_PTIME    = 5'd12,
      CMD_BRANGE   = 5'd13,
      CMD_TUNE     = 5'd14,
      CMD_MONO     = 5'd15,
      CMD_PROGRAM  = 5'd16
   } command_type;

   typedef enum logic [1:0] {
      JOB_SINGLE,
      JOB_RELEASE,
      JOB_PAIR,
      JOB_RESET
   } job_kind_type;

   typedef struct packed {
      job_kind_type           kind;
      command_type            cmd;
      logic [6:0]             note;
      logic signed [17:0]     amount;
      logic [6:0]             second;
      logic [NOTE_COUNT-1:0]  held;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic       busy;
      logic [3:0] step;
      logic [3:0] final_step;
   } back_status_type;

endpackage

@@ sv/mch_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_front
// accepts channel messages, filters and classifies them, keeps the channel
// state and hands one job per producing message to the queue
// ----------------------------------------------------------------------------
module mch_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [4:0]                csr_receive_channel,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_kind,
   input  logic [3:0]                req_channel,
   input  logic [6:0]                req_first_data,
   input  logic [6:0]                req_second_data,
   input  logic signed [13:0]        req_bend_amount,
   input  mch_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output mch_pkg::job_type          push_job
);
   import mch_pkg::*;

   localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
   localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
   localparam logic [2:0] KIND_CONTROL  = 3'd2;
   localparam logic [2:0] KIND_PROGRAM  = 3'd3;
   localparam logic [2:0] KIND_PRESSURE = 3'd4;
   localparam logic [2:0] KIND_BEND     = 3'd5;

   localparam logic [6:0] CC_BANK      = 7'd0;
   localparam logic [6:0] CC_MOD       = 7'd1;
   localparam logic [6:0] CC_PTIME     = 7'd5;
   localparam logic [6:0] CC_DATA      = 7'd6;
   localparam logic [6:0] CC_VOL       = 7'd7;
   localparam logic [6:0] CC_PAN       = 7'd10;
   localparam logic [6:0] CC_EXPR      = 7'd11;
   localparam logic [6:0] CC_SUSTAIN   = 7'd64;
   localparam logic [6:0] CC_PORTA     = 7'd65;
   localparam logic [6:0] CC_REVERB    = 7'd91;
   localparam logic [6:0] CC_CHORUS    = 7'd93;
   localparam logic [6:0] CC_RPN_LSB   = 7'd100;
   localparam logic [6:0] CC_RPN_MSB   = 7'd101;
   localparam logic [6:0] CC_SOUND_OFF = 7'd120;
   localparam logic [6:0] CC_RESET     = 7'd121;
   localparam logic [6:0] CC_ALL_OFF   = 7'd123;
   localparam logic [6:0] CC_OMNI_OFF  = 7'd124;
   localparam logic [6:0] CC_OMNI_ON   = 7'd125;
   localparam logic [6:0] CC_MONO      = 7'd126;
   localparam logic [6:0] CC_POLY      = 7'd127;

   localparam logic [6:0] RPN_BEND_RANGE = 7'd0;
   localparam logic [6:0] RPN_FINE       = 7'd1;
   localparam logic [6:0] RPN_COARSE     = 7'd2;
   localparam logic [6:0] BANK_FIXED     = 7'd80;
   localparam logic [6:0] SEL_NONE       = 7'd127;
   localparam logic [6:0] DEPTH_RESET    = 7'd127;
   localparam logic [6:0] BEND_RANGE_MAX = 7'd12;

   logic [4:0]            rx_chan_ff, rx_chan_in;
   logic                  sustain_ff, sustain_in;
   logic [NOTE_COUNT-1:0] held_ff, held_in;
   logic [6:0]            bank_ff, bank_in;
   logic [6:0]            psh_ff, psh_in;
   logic [6:0]            psl_ff, psl_in;
   logic [6:0]            reverb_ff, reverb_in;
   logic [6:0]            chorus_ff, chorus_in;
   logic signed [11:0]    fine_ff, fine_in;
   logic signed [17:0]    coarse_ff, coarse_in;

   logic                  accept;
   logic                  chan_ok;
   logic signed [7:0]     centered;
   logic signed [11:0]    fine_calc;
   logic signed [17:0]    coarse_calc;

   assign csr_ready   = 1'b1;
   assign req_ready   = !q_status.full;
   assign accept      = req_valid && req_ready;
   assign chan_ok     = rx_chan_ff[4] || (rx_chan_ff == {1'b0, req_channel});
   assign centered    = $signed({1'b0, req_second_data}) - 8'sd64;
   assign fine_calc   = 12'(centered) * 12'sd25;
   assign coarse_calc = 18'(centered) * 18'sd1600;

   always_comb begin
      rx_chan_in = csr_valid ? csr_receive_channel : rx_chan_ff;
      sustain_in = sustain_ff;
      held_in    = held_ff;
      bank_in    = bank_ff;
      psh_in     = psh_ff;
      psl_in     = psl_ff;
      reverb_in  = reverb_ff;
      chorus_in  = chorus_ff;
      fine_in    = fine_ff;
      coarse_in  = coarse_ff;

      push_valid      = 1'b0;
      push_job.kind   = JOB_SINGLE;
      push_job.cmd    = CMD_NOTEON;
      push_job.note   = 7'd0;
      push_job.amount = 18'sd0;
      push_job.second = 7'd0;
      push_job.held   = held_ff;

      if (accept) begin
         if (req_kind == KIND_PROGRAM) begin
            push_job.cmd = CMD_PROGRAM;
            if (bank_ff == BANK_FIXED) begin
               push_valid      = !req_first_data[6];
               push_job.second = req_first_data;
            end else begin
               push_valid      = 1'b1;
               push_job.amount = req_first_data[6] ? 18'sd2 : 18'sd1;
               push_job.second = {1'b0, req_first_data[5:0]};
            end
         end else if (chan_ok) begin
            unique case (req_kind)
               KIND_NOTE_ON, KIND_NOTE_OFF: begin
                  if (req_kind == KIND_NOTE_ON && req_second_data != 7'd0) begin
                     held_in[req_first_data] = 1'b0;
                     push_valid      = 1'b1;
                     push_job.note   = req_first_data;
                     push_job.amount = {11'd0, req_second_data};
                  end else if (sustain_ff) begin
                     held_in[req_first_data] = 1'b1;
                  end else begin
                     push_valid    = 1'b1;
                     push_job.cmd  = CMD_NOTEOFF;
                     push_job.note = req_first_data;
                  end
               end
               KIND_PRESSURE: begin
                  push_valid      = 1'b1;
                  push_job.cmd    = CMD_AFTER;
                  push_job.amount = {11'd0, req_second_data};
               end
               KIND_BEND: begin
                  push_valid      = 1'b1;
                  push_job.cmd    = CMD_BEND;
                  push_job.amount = {{4{req_bend_amount[13]}}, req_bend_amount};
               end
               KIND_CONTROL: begin
                  push_job.amount = {11'd0, req_second_data};
                  unique case (req_first_data)
                     CC_BANK: bank_in = req_second_data;
                     CC_MOD: begin
                        push_valid   = 1'b1;
                        push_job.cmd = CMD_MOD;
                     end
                     CC_PTIME: begin
                        push_valid   = 1'b1;
                        push_job.cmd = CMD_PTIME;
                     end
                     CC_VOL: begin
                        push_valid   = 1'b1;
                        push_job.cmd = CMD_VOL;
                     end
                     CC_PAN: begin
                        push_valid   = 1'b1;
                        push_job.cmd = CMD_PAN;
                     end
                     CC_EXPR: begin
                        push_valid   = 1'b1;
                        push_job.cmd = CMD_EXPR;
                     end
                     CC_PORTA: begin
                        push_valid      = 1'b1;
                        push_job.cmd    = CMD_PSWITCH;
                        push_job.amount = req_second_data[6] ? 18'sd1 : 18'sd0;
                     end
                     CC_REVERB, CC_CHORUS: begin
                        push_valid   = 1'b1;
                        push_job.cmd = CMD_SENDS;
                        if (req_first_data == CC_REVERB) begin
                           reverb_in = req_second_data;
                        end else begin
                           chorus_in = req_second_data;
                        end
                        push_job.amount = {11'd0, reverb_in};
                        push_job.second = chorus_in;
                     end
                     CC_RPN_MSB: begin
                        psh_in = req_second_data;
                        psl_in = 7'd0;
                     end
                     CC_RPN_LSB: psl_in = req_second_data;
                     CC_DATA: begin
                        if (psh_ff == 7'd0) begin
                           priority if (psl_ff == RPN_BEND_RANGE) begin
                              push_valid      = 1'b1;
                              push_job.cmd    = CMD_BRANGE;
                              push_job.amount = (req_second_data > BEND_RANGE_MAX) ?
                                                {11'd0, BEND_RANGE_MAX} :
                                                {11'd0, req_second_data};
                           end else if (psl_ff == RPN_FINE) begin
                              fine_in         = fine_calc;
                              push_valid      = 1'b1;
                              push_job.cmd    = CMD_TUNE;
                              push_job.amount = 18'(fine_calc) + coarse_ff;
                           end else if (psl_ff == RPN_COARSE) begin
                              coarse_in       = coarse_calc;
                              push_valid      = 1'b1;
                              push_job.cmd    = CMD_TUNE;
                              push_job.amount = 18'(fine_ff) + coarse_calc;
                           end else begin
                              push_valid = 1'b0;
                           end
                        end
                     end
                     CC_SUSTAIN: begin
                        sustain_in = req_second_data[6];
                        if (!req_second_data[6]) begin
                           push_valid    = 1'b1;
                           push_job.kind = JOB_RELEASE;
                           held_in       = '0;
                        end
                     end
                     CC_SOUND_OFF, CC_ALL_OFF: begin
                        sustain_in      = 1'b0;
                        held_in         = '0;
                        push_valid      = 1'b1;
                        push_job.cmd    = CMD_ALLOFF;
                        push_job.amount = 18'sd0;
                     end
                     CC_OMNI_OFF, CC_OMNI_ON: begin
                        push_valid      = 1'b1;
                        push_job.cmd    = CMD_ALLOFF;
                        push_job.amount = 18'sd0;
                     end
                     CC_MONO, CC_POLY: begin
                        push_valid      = 1'b1;
                        push_job.kind   = JOB_PAIR;
                        push_job.amount = (req_first_data == CC_MONO) ? 18'sd1 : -18'sd1;
                     end
                     CC_RESET: begin
                        push_valid    = 1'b1;
                        push_job.kind = JOB_RESET;
                        psh_in        = SEL_NONE;
                        psl_in        = SEL_NONE;
                     end
                     default: push_valid = 1'b0;
                  endcase
               end
               default: push_valid = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_chan_ff <= 5'd16;
         sustain_ff <= 1'b0;
         held_ff    <= '0;
         bank_ff    <= 7'd0;
         psh_ff     <= SEL_NONE;
         psl_ff     <= SEL_NONE;
         reverb_ff  <= DEPTH_RESET;
         chorus_ff  <= DEPTH_RESET;
         fine_ff    <= 12'sd0;
         coarse_ff  <= 18'sd0;
      end else begin
         rx_chan_ff <= rx_chan_in;
         sustain_ff <= sustain_in;
         held_ff    <= held_in;
         bank_ff    <= bank_in;
         psh_ff     <= psh_in;
         psl_ff     <= psl_in;
         reverb_ff  <= reverb_in;
         chorus_ff  <= chorus_in;
         fine_ff    <= fine_in;
         coarse_ff  <= coarse_in;
      end
   end

endmodule

@@ sv/mch_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_queue
// short job queue, front to back; one push while not full and one pop a cycle
// ----------------------------------------------------------------------------
module mch_queue #(
   parameter int DEPTH = mch_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  mch_pkg::job_type          push_job,
   input  logic                      pop,
   output mch_pkg::job_type          pop_job,
   output mch_pkg::queue_status_type q_status
);
   import mch_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign pop_job        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ sv/mch_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_back
// sequences each job into its synth command words, one word per cycle
// while rsp_ready does not stall it, through the output register
// ----------------------------------------------------------------------------
module mch_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mch_pkg::queue_status_type q_status,
   input  mch_pkg::job_type          pop_job,
   output logic                      pop,
   output mch_pkg::back_status_type  back_status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [4:0]                rsp_command,
   output logic [6:0]                rsp_note_number,
   output logic signed [17:0]        rsp_amount,
   output logic [6:0]                rsp_second_amount,
   output logic [1:0]                rsp_word_index,
   output logic [31:0]               rsp_release_mask,
   output logic                      rsp_last
);
   import mch_pkg::*;

   localparam logic [3:0] STEPS_SINGLE  = 4'd0;
   localparam logic [3:0] STEPS_RELEASE = 4'd3;
   localparam logic [3:0] STEPS_PAIR    = 4'd1;
   localparam logic [3:0] STEPS_RESET   = 4'd8;

   // controller reset sequence
   function automatic command_type reset_cmd(input logic [3:0] s);
      command_type c;
      unique case (s)
         4'd0:    c = CMD_MOD;
         4'd1:    c = CMD_EXPR;
         4'd2:    c = CMD_AFTER;
         4'd3:    c = CMD_BEND;
         4'd4:    c = CMD_VOL;
         4'd5:    c = CMD_PAN;
         4'd6:    c = CMD_SENDS;
         4'd7:    c = CMD_PSWITCH;
         default: c = CMD_PTIME;
      endcase
      return c;
   endfunction

   function automatic logic signed [17:0] reset_amount(input logic [3:0] s);
      logic signed [17:0] a;
      unique case (s)
         4'd4:       a = 18'sd127;
         4'd5:       a = 18'sd64;
         4'd6:       a = 18'sd127;
         4'd7, 4'd8: a = -18'sd1;
         default:    a = 18'sd0;
      endcase
      return a;
   endfunction

   job_type            cur_ff;
   logic               busy_ff, busy_in;
   logic [3:0]         step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         command_ff, command_in;
   logic [6:0]         note_ff, note_in;
   logic signed [17:0] amount_ff, amount_in;
   logic [6:0]         second_ff, second_in;
   logic [1:0]         word_ff, word_in;
   logic [31:0]        mask_ff, mask_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic               advance;
   logic               done;
   logic [3:0]         final_step;

   always_comb begin
      unique case (cur_ff.kind)
         JOB_SINGLE:  final_step = STEPS_SINGLE;
         JOB_RELEASE: final_step = STEPS_RELEASE;
         JOB_PAIR:    final_step = STEPS_PAIR;
         default:     final_step = STEPS_RESET;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = busy_ff && out_free;
   assign done     = advance && (step_ff == final_step);
   assign pop      = !q_status.empty && (!busy_ff || done);

   assign back_status.busy       = busy_ff;
   assign back_status.step       = step_ff;
   assign back_status.final_step = final_step;

   always_comb begin
      command_in = cur_ff.cmd;
      note_in    = cur_ff.note;
      amount_in  = cur_ff.amount;
      second_in  = cur_ff.second;
      word_in    = 2'd0;
      mask_in    = 32'd0;
      last_in    = (step_ff == final_step);
      unique case (cur_ff.kind)
         JOB_SINGLE: begin
         end
         JOB_RELEASE: begin
            command_in = CMD_RELEASE;
            note_in    = 7'd0;
            amount_in  = 18'sd0;
            second_in  = 7'd0;
            word_in    = step_ff[1:0];
            mask_in    = cur_ff.held[{step_ff[1:0], 5'd0} +: 32];
         end
         JOB_PAIR: begin
            command_in = (step_ff == 4'd0) ? CMD_ALLOFF : CMD_MONO;
            note_in    = 7'd0;
            amount_in  = (step_ff == 4'd0) ? 18'sd0 : cur_ff.amount;
            second_in  = 7'd0;
         end
         default: begin
            command_in = reset_cmd(step_ff);
            note_in    = 7'd0;
            amount_in  = reset_amount(step_ff);
            second_in  = (step_ff == 4'd6) ? 7'd127 : 7'd0;
         end
      endcase

      rsp_valid_in = out_free ? advance : rsp_valid_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      if (advance) begin
         step_in = done ? 4'd0 : step_ff + 4'd1;
      end
      if (pop) begin
         busy_in = 1'b1;
         step_in = 4'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_job;
      end
      if (advance) begin
         command_ff <= command_in;
         note_ff    <= note_in;
         amount_ff  <= amount_in;
         second_ff  <= second_in;
         word_ff    <= word_in;
         mask_ff    <= mask_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = command_ff;
   assign rsp_note_number   = note_ff;
   assign rsp_amount        = amount_ff;
   assign rsp_second_amount = second_ff;
   assign rsp_word_index    = word_ff;
   assign rsp_release_mask  = mask_ff;
   assign rsp_last          = last_ff;

endmodule

@@ sv/midi_channel_message_handler.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// midi_channel_message_handler
// turns decoded midi channel messages into synth command words
// ----------------------------------------------------------------------------
// A message word is taken whenever the job queue has room, so messages can
// arrive back to back; the front end applies all channel state at once.
// Each message that produces output becomes one job, and the back end
// sequencer drives one command word per cycle into the output register
// while rsp_ready does not stall it: a message yields one word for a single
// command, two for mono/poly, four for a pedal release and nine for a
// controller reset, which sets the sustained rate. There is no start-up
// clearing pass; the block is ready right after reset. receive_channel values
// of 16 and above accept every channel; program change is never filtered.
module midi_channel_message_handler #(
   parameter int QUEUE_DEPTH = mch_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_receive_channel,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_kind,
   input  logic [3:0]         req_channel,
   input  logic [6:0]         req_first_data,
   input  logic [6:0]         req_second_data,
   input  logic signed [13:0] req_bend_amount,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_command,
   output logic [6:0]         rsp_note_number,
   output logic signed [17:0] rsp_amount,
   output logic [6:0]         rsp_second_amount,
   output logic [1:0]         rsp_word_index,
   output logic [31:0]        rsp_release_mask,
   output logic               rsp_last
);
   import mch_pkg::*;

   queue_status_type q_status;
   back_status_type  back_status;
   job_type          push_job;
   job_type          pop_job;
   logic             push_valid;
   logic             pop;

   mch_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_receive_channel (csr_receive_channel),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_channel         (req_channel),
      .req_first_data      (req_first_data),
      .req_second_data     (req_second_data),
      .req_bend_amount     (req_bend_amount),
      .q_status            (q_status),
      .push_valid          (push_valid),
      .push_job            (push_job)
   );

   mch_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .pop_job    (pop_job),
      .q_status   (q_status)
   );

   mch_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop_job           (pop_job),
      .pop               (pop),
      .back_status       (back_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command       (rsp_command),
      .rsp_note_number   (rsp_note_number),
      .rsp_amount        (rsp_amount),
      .rsp_second_amount (rsp_second_amount),
      .rsp_word_index    (rsp_word_index),
      .rsp_release_mask  (rsp_release_mask),
      .rsp_last          (rsp_last)
   );

   `ASSERT_IMPLY(a_step_in_range, clock, reset, back_status.busy, back_status.step <= back_status.final_step)
   `ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, !q_status.empty)
   `ASSERT_IMPLY(a_push_has_room, clock, reset, push_valid, !q_status.full)
   `ASSERT_NEXT(a_pop_loads_job, clock, reset, pop, back_status.busy && back_status.step == 4'd0)

endmodule

@@ sim/midi_command_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_command_checker
// Message and controller codes shared by the testbench, and a checker that
// watches the csr, request and response channels of the midi channel message
// handler. It keeps its own copy of the channel state, predicts the command
// words of every accepted message word, and compares each response word
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
package midi_msg_pkg;

   localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
   localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
   localparam logic [2:0] KIND_CONTROL  = 3'd2;
   localparam logic [2:0] KIND_PROGRAM  = 3'd3;
   localparam logic [2:0] KIND_PRESSURE = 3'd4;
   localparam logic [2:0] KIND_BEND     = 3'd5;
   localparam logic [2:0] KIND_SPARE    = 3'd6;

   localparam logic [6:0] CC_BANK       = 7'd0;
   localparam logic [6:0] CC_MOD        = 7'd1;
   localparam logic [6:0] CC_PTIME      = 7'd5;
   localparam logic [6:0] CC_DATA       = 7'd6;
   localparam logic [6:0] CC_VOL        = 7'd7;
   localparam logic [6:0] CC_PAN        = 7'd10;
   localparam logic [6:0] CC_EXPR       = 7'd11;
   localparam logic [6:0] CC_BANK_LSB   = 7'd38;
   localparam logic [6:0] CC_SUSTAIN    = 7'd64;
   localparam logic [6:0] CC_PORTA      = 7'd65;
   localparam logic [6:0] CC_REVERB     = 7'd91;
   localparam logic [6:0] CC_CHORUS     = 7'd93;
   localparam logic [6:0] CC_RPN_LSB    = 7'd100;
   localparam logic [6:0] CC_RPN_MSB    = 7'd101;
   localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
   localparam logic [6:0] CC_RESET_CTRL = 7'd121;
   localparam logic [6:0] CC_NOTES_OFF  = 7'd123;
   localparam logic [6:0] CC_OMNI_OFF   = 7'd124;
   localparam logic [6:0] CC_OMNI_ON    = 7'd125;
   localparam logic [6:0] CC_MONO_ON    = 7'd126;
   localparam logic [6:0] CC_POLY_ON    = 7'd127;

   localparam logic [6:0] RPN_BEND_RANGE  = 7'd0;
   localparam logic [6:0] RPN_FINE_TUNE   = 7'd1;
   localparam logic [6:0] RPN_COARSE_TUNE = 7'd2;

   localparam logic [6:0] DRUM_BANK    = 7'd80;
   localparam logic [4:0] ALL_CHANNELS = 5'd16;

endpackage

module midi_command_checker
   import mch_pkg::*;
   import midi_msg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [4:0]         csr_receive_channel,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_kind,
   input  logic [3:0]         req_channel,
   input  logic [6:0]         req_first_data,
   input  logic [6:0]         req_second_data,
   input  logic signed [13:0] req_bend_amount,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [4:0]         rsp_command,
   input  logic [6:0]         rsp_note_number,
   input  logic signed [17:0] rsp_amount,
   input  logic [6:0]         rsp_second_amount,
   input  logic [1:0]         rsp_word_index,
   input  logic [31:0]        rsp_release_mask,
   input  logic               rsp_last,
   output int                 mismatch_count,
   output int                 pending_count
);

   typedef struct packed {
      command_type        command;
      logic [6:0]         note;
      logic signed [17:0] amount;
      logic [6:0]         second;
      logic [1:0]         word_index;
      logic [31:0]        mask;
      logic               last;
   } synth_word_type;

   synth_word_type expected_words[$];
   synth_word_type oldest_word;

   logic [4:0]  rx_channel;
   logic        pedal_down;
   logic [31:0] held_map [4];
   logic [6:0]  bank_msb;
   logic [6:0]  rpn_msb;
   logic [6:0]  rpn_lsb;
   logic [6:0]  reverb_send;
   logic [6:0]  chorus_send;
   int          fine_tune_sc;
   int          coarse_tune_sc;

   task automatic add_word(input command_type command, input logic [6:0] note,
                           input int amount, input logic [6:0] second,
                           input logic [1:0] word_index, input logic [31:0] mask);
      synth_word_type w;
      w.command    = command;
      w.note       = note;
      w.amount     = amount[17:0];
      w.second     = second;
      w.word_index = word_index;
      w.mask       = mask;
      w.last       = 1'b0;
      expected_words.push_back(w);
   endtask

   task automatic clear_held_map();
      for (int i = 0; i < 4; i++) begin
         held_map[i] = '0;
      end
   endtask

   task automatic note_released(input logic [6:0] note);
      if (pedal_down) begin
         held_map[note[6:5]][note[4:0]] = 1'b1;
      end else begin
         add_word(CMD_NOTEOFF, note, 0, 7'd0, 2'd0, 32'd0);
      end
   endtask

   task automatic apply_controller(input logic [6:0] cc, input logic [6:0] v);
      case (cc)
         CC_BANK: bank_msb = v;
         CC_MOD: add_word(CMD_MOD, 7'd0, int'(v), 7'd0, 2'd0, 32'd0);
         CC_PTIME: add_word(CMD_PTIME, 7'd0, int'(v), 7'd0, 2'd0, 32'd0);
         CC_VOL: add_word(CMD_VOL, 7'd0, int'(v), 7'd0, 2'd0, 32'd0);
         CC_PAN: add_word(CMD_PAN, 7'd0, int'(v), 7'd0, 2'd0, 32'd0);
         CC_EXPR: add_word(CMD_EXPR, 7'd0, int'(v), 7'd0, 2'd0, 32'd0);
         CC_PORTA: add_word(CMD_PSWITCH, 7'd0, (v >= 7'd64) ? 1 : 0, 7'd0, 2'd0, 32'd0);
         CC_REVERB, CC_CHORUS: begin
            if (cc == CC_REVERB) reverb_send = v;
            else chorus_send = v;
            add_word(CMD_SENDS, 7'd0, int'(reverb_send), chorus_send, 2'd0, 32'd0);
         end
         CC_RPN_MSB: begin
            rpn_msb = v;
            rpn_lsb = 7'd0;
         end
         CC_RPN_LSB: rpn_lsb = v;
         CC_DATA: begin
            if (rpn_msb == 7'd0) begin
               if (rpn_lsb == RPN_BEND_RANGE) begin
                  add_word(CMD_BRANGE, 7'd0, (v > 7'd12) ? 12 : int'(v), 7'd0, 2'd0, 32'd0);
               end else if (rpn_lsb == RPN_FINE_TUNE) begin
                  fine_tune_sc = (int'(v) - 64) * 25;
                  add_word(CMD_TUNE, 7'd0, fine_tune_sc + coarse_tune_sc, 7'd0, 2'd0, 32'd0);
               end else if (rpn_lsb == RPN_COARSE_TUNE) begin
                  coarse_tune_sc = (int'(v) - 64) * 1600;
                  add_word(CMD_TUNE, 7'd0, fine_tune_sc + coarse_tune_sc, 7'd0, 2'd0, 32'd0);
               end
            end
         end
         CC_SUSTAIN: begin
            pedal_down = (v >= 7'd64);
            if (!pedal_down) begin
               for (int i = 0; i < 4; i++) begin
                  add_word(CMD_RELEASE, 7'd0, 0, 7'd0, i[1:0], held_map[i]);
               end
               clear_held_map();
            end
         end
         CC_SOUND_OFF, CC_NOTES_OFF: begin
            pedal_down = 1'b0;
            clear_held_map();
            add_word(CMD_ALLOFF, 7'd0, 0, 7'd0, 2'd0, 32'd0);
         end
         CC_RESET_CTRL: begin
            add_word(CMD_MOD, 7'd0, 0, 7'd0, 2'd0, 32'd0);
            add_word(CMD_EXPR, 7'd0, 0, 7'd0, 2'd0, 32'd0);
            add_word(CMD_AFTER, 7'd0, 0, 7'd0, 2'd0, 32'd0);
            add_word(CMD_BEND, 7'd0, 0, 7'd0, 2'd0, 32'd0);
            add_word(CMD_VOL, 7'd0, 127, 7'd0, 2'd0, 32'd0);
            add_word(CMD_PAN, 7'd0, 64, 7'd0, 2'd0, 32'd0);
            add_word(CMD_SENDS, 7'd0, 127, 7'd127, 2'd0, 32'd0);
            add_word(CMD_PSWITCH, 7'd0, -1, 7'd0, 2'd0, 32'd0);
            add_word(CMD_PTIME, 7'd0, -1, 7'd0, 2'd0, 32'd0);
            rpn_msb = 7'd127;
            rpn_lsb = 7'd127;
         end
         CC_OMNI_OFF, CC_OMNI_ON: add_word(CMD_ALLOFF, 7'd0, 0, 7'd0, 2'd0, 32'd0);
         CC_MONO_ON, CC_POLY_ON: begin
            add_word(CMD_ALLOFF, 7'd0, 0, 7'd0, 2'd0, 32'd0);
            add_word(CMD_MONO, 7'd0, (cc == CC_MONO_ON) ? 1 : -1, 7'd0, 2'd0, 32'd0);
         end
         default: ;
      endcase
   endtask

   task automatic predict_commands(input logic [2:0] kind, input logic [3:0] chan,
                                   input logic [6:0] d1, input logic [6:0] d2,
                                   input logic signed [13:0] bend);
      int             first_new;
      synth_word_type final_word;
      first_new = expected_words.size();
      if (kind == KIND_PROGRAM) begin
         if (bank_msb == DRUM_BANK) begin
            if (d1 < 7'd64) add_word(CMD_PROGRAM, 7'd0, 0, d1, 2'd0, 32'd0);
         end else begin
            add_word(CMD_PROGRAM, 7'd0, (d1 < 7'd64) ? 1 : 2, {1'b0, d1[5:0]}, 2'd0, 32'd0);
         end
      end else if (kind <= KIND_BEND &&
                   (rx_channel >= ALL_CHANNELS || rx_channel == {1'b0, chan})) begin
         case (kind)
            KIND_NOTE_ON: begin
               if (d2 == 7'd0) begin
                  note_released(d1);
               end else begin
                  held_map[d1[6:5]][d1[4:0]] = 1'b0;
                  add_word(CMD_NOTEON, d1, int'(d2), 7'd0, 2'd0, 32'd0);
               end
            end
            KIND_NOTE_OFF: note_released(d1);
            KIND_CONTROL: apply_controller(d1, d2);
            KIND_PRESSURE: add_word(CMD_AFTER, 7'd0, int'(d2), 7'd0, 2'd0, 32'd0);
            default: add_word(CMD_BEND, 7'd0, int'(bend), 7'd0, 2'd0, 32'd0);
         endcase
      end
      if (expected_words.size() > first_new) begin
         final_word = expected_words.pop_back();
         final_word.last = 1'b1;
         expected_words.push_back(final_word);
      end
   endtask

   task automatic check_field(input string name, input logic signed [32:0] want,
                              input logic signed [32:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         rx_channel     = ALL_CHANNELS;
         pedal_down     = 1'b0;
         clear_held_map();
         bank_msb       = 7'd0;
         rpn_msb        = 7'd127;
         rpn_lsb        = 7'd127;
         reverb_send    = 7'd127;
         chorus_send    = 7'd127;
         fine_tune_sc   = 0;
         coarse_tune_sc = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected command word, command %0d, amount %0d",
                        $time, rsp_command, rsp_amount);
               mismatch_count++;
            end else begin
               oldest_word = expected_words.pop_front();
               check_field("command", oldest_word.command, rsp_command);
               check_field("note_number", oldest_word.note, rsp_note_number);
               check_field("amount", oldest_word.amount, rsp_amount);
               check_field("second_amount", oldest_word.second, rsp_second_amount);
               check_field("word_index", oldest_word.word_index, rsp_word_index);
               check_field("release_mask", oldest_word.mask, rsp_release_mask);
               check_field("last", oldest_word.last, rsp_last);
            end
         end
         if (csr_valid && csr_ready) begin
            rx_channel = csr_receive_channel;
         end
         if (req_valid && req_ready) begin
            predict_commands(req_kind, req_channel, req_first_data, req_second_data,
                             req_bend_amount);
         end
      end
      pending_count = expected_words.size();
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the midi channel message handler with a short directed sequence and
// then random message sequences (sustain, rpn, bank and program, controllers,
// noise) under three receive channel settings and three idle patterns. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import mch_pkg::*;
   import midi_msg_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 24;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [4:0]         csr_receive_channel;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_kind;
   logic [3:0]         req_channel;
   logic [6:0]         req_first_data;
   logic [6:0]         req_second_data;
   logic signed [13:0] req_bend_amount;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [4:0]         rsp_command;
   logic [6:0]         rsp_note_number;
   logic signed [17:0] rsp_amount;
   logic [6:0]         rsp_second_amount;
   logic [1:0]         rsp_word_index;
   logic [31:0]        rsp_release_mask;
   logic               rsp_last;

   int         mismatch_count;
   int         pending_count;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         counted_msgs;
   int         quiet_cycles;
   logic [4:0] rx_setting;

   logic [6:0] known_ccs [21] = '{
      CC_BANK, CC_MOD, CC_PTIME, CC_DATA, CC_VOL, CC_PAN, CC_EXPR, CC_BANK_LSB,
      CC_SUSTAIN, CC_PORTA, CC_REVERB, CC_CHORUS, CC_RPN_LSB, CC_RPN_MSB,
      CC_SOUND_OFF, CC_RESET_CTRL, CC_NOTES_OFF, CC_OMNI_OFF, CC_OMNI_ON,
      CC_MONO_ON, CC_POLY_ON
   };

   midi_channel_message_handler DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_receive_channel (csr_receive_channel),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_channel         (req_channel),
      .req_first_data      (req_first_data),
      .req_second_data     (req_second_data),
      .req_bend_amount     (req_bend_amount),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_command         (rsp_command),
      .rsp_note_number     (rsp_note_number),
      .rsp_amount          (rsp_amount),
      .rsp_second_amount   (rsp_second_amount),
      .rsp_word_index      (rsp_word_index),
      .rsp_release_mask    (rsp_release_mask),
      .rsp_last            (rsp_last)
   );

   midi_command_checker command_check (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_receive_channel (csr_receive_channel),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_channel         (req_channel),
      .req_first_data      (req_first_data),
      .req_second_data     (req_second_data),
      .req_bend_amount     (req_bend_amount),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_command         (rsp_command),
      .rsp_note_number     (rsp_note_number),
      .rsp_amount          (rsp_amount),
      .rsp_second_amount   (rsp_second_amount),
      .rsp_word_index      (rsp_word_index),
      .rsp_release_mask    (rsp_release_mask),
      .rsp_last            (rsp_last),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_msg(input logic [2:0] kind, input logic [3:0] chan,
                           input logic [6:0] d1, input logic [6:0] d2,
                           input logic signed [13:0] bend);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_channel     <= chan;
      req_first_data  <= d1;
      req_second_data <= d2;
      req_bend_amount <= bend;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      counted_msgs++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_rx(input logic [4:0] value);
      wait_idle();
      csr_valid           <= 1'b1;
      csr_receive_channel <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid  <= 1'b0;
      rx_setting = value;
   endtask

   function automatic logic [3:0] pick_channel();
      if (rx_setting < ALL_CHANNELS && $urandom_range(99) < 75) return rx_setting[3:0];
      return 4'($urandom_range(15));
   endfunction

   function automatic logic [6:0] rand7();
      return 7'($urandom_range(127));
   endfunction

   function automatic logic signed [13:0] rand_bend();
      return 14'($urandom_range(16383));
   endfunction

   task automatic random_burst();
      logic [3:0] ch;
      logic [6:0] note;
      logic [6:0] sel;
      ch = pick_channel();
      case ($urandom_range(9))
         0, 1: begin
            send_msg(KIND_CONTROL, ch, CC_SUSTAIN, 7'(64 + $urandom_range(63)), rand_bend());
            repeat ($urandom_range(1, 6)) begin
               note = rand7();
               send_msg(KIND_NOTE_ON, ch, note, 7'($urandom_range(1, 127)), rand_bend());
               if ($urandom_range(3) != 0) begin
                  if ($urandom_range(1)) send_msg(KIND_NOTE_OFF, ch, note, rand7(), rand_bend());
                  else send_msg(KIND_NOTE_ON, ch, note, 7'd0, rand_bend());
               end
            end
            if ($urandom_range(5) == 0)
               send_msg(KIND_CONTROL, ch, $urandom_range(1) ? CC_SOUND_OFF : CC_NOTES_OFF,
                        rand7(), rand_bend());
            else
               send_msg(KIND_CONTROL, ch, CC_SUSTAIN, 7'($urandom_range(63)), rand_bend());
         end
         2: begin
            sel = ($urandom_range(4) == 0) ? rand7() : 7'd0;
            send_msg(KIND_CONTROL, ch, CC_RPN_MSB, sel, rand_bend());
            if ($urandom_range(3) != 0) begin
               sel = ($urandom_range(4) == 0) ? rand7() : 7'($urandom_range(2));
               send_msg(KIND_CONTROL, ch, CC_RPN_LSB, sel, rand_bend());
            end
            repeat ($urandom_range(1, 2)) send_msg(KIND_CONTROL, ch, CC_DATA, rand7(), rand_bend());
         end
         3: begin
            send_msg(KIND_CONTROL, ch, CC_BANK, $urandom_range(1) ? DRUM_BANK : rand7(),
                     rand_bend());
            repeat ($urandom_range(1, 3)) send_msg(KIND_PROGRAM, pick_channel(), rand7(),
                                                   rand7(), rand_bend());
         end
         4, 5: begin
            sel = ($urandom_range(5) == 0) ? rand7() : known_ccs[$urandom_range(20)];
            send_msg(KIND_CONTROL, ch, sel, rand7(), rand_bend());
         end
         6: begin
            note = rand7();
            send_msg(KIND_NOTE_ON, ch, note, rand7(), rand_bend());
            send_msg(KIND_NOTE_OFF, ch, note, rand7(), rand_bend());
         end
         7: send_msg($urandom_range(1) ? KIND_PRESSURE : KIND_BEND, ch, rand7(), rand7(),
                     rand_bend());
         default: send_msg(3'($urandom_range(7)), 4'($urandom_range(15)), rand7(), rand7(),
                           rand_bend());
      endcase
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct,
                               input logic [4:0] rx, input int target);
      write_rx(rx);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      counted_msgs  = 0;
      while (counted_msgs < target) begin
         random_burst();
         if ($urandom_range(39) == 0) wait_idle();
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_receive_channel = '0;
      req_valid           = 1'b0;
      req_kind            = '0;
      req_channel         = '0;
      req_first_data      = '0;
      req_second_data     = '0;
      req_bend_amount     = '0;
      rsp_ready           = 1'b0;
      send_idle_pct       = 32;
      recv_idle_pct       = 59;
      counted_msgs        = 0;
      quiet_cycles        = 0;
      rx_setting          = ALL_CHANNELS;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: note extremes, pedal hold and release, rpn, mode and reset controllers
      write_rx(5'd5);
      send_msg(KIND_NOTE_ON, 4'd5, 7'd0, 7'd127, 14'sd0);
      send_msg(KIND_NOTE_ON, 4'd5, 7'd127, 7'd1, 14'sd0);
      send_msg(KIND_NOTE_ON, 4'd5, 7'd60, 7'd0, 14'sd0);
      send_msg(KIND_NOTE_OFF, 4'd5, 7'd64, 7'd127, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_SUSTAIN, 7'd127, 14'sd0);
      send_msg(KIND_NOTE_OFF, 4'd5, 7'd0, 7'd0, 14'sd0);
      send_msg(KIND_NOTE_OFF, 4'd5, 7'd127, 7'd64, 14'sd0);
      send_msg(KIND_NOTE_ON, 4'd5, 7'd33, 7'd0, 14'sd0);
      send_msg(KIND_NOTE_ON, 4'd5, 7'd127, 7'd10, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_SUSTAIN, 7'd63, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_RPN_MSB, RPN_BEND_RANGE, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_DATA, 7'd127, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_RPN_LSB, RPN_FINE_TUNE, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_DATA, 7'd0, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_RPN_LSB, RPN_COARSE_TUNE, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_DATA, 7'd0, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_RESET_CTRL, 7'd0, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_MONO_ON, 7'd0, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_POLY_ON, 7'd0, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_SOUND_OFF, 7'd0, 14'sd0);
      send_msg(KIND_CONTROL, 4'd5, CC_BANK, DRUM_BANK, 14'sd0);
      send_msg(KIND_PROGRAM, 4'd9, 7'd63, 7'd0, 14'sd0);
      send_msg(KIND_PROGRAM, 4'd9, 7'd64, 7'd0, 14'sd0);
      send_msg(KIND_BEND, 4'd5, 7'd0, 7'd0, -14'sd8192);
      send_msg(KIND_BEND, 4'd5, 7'd127, 7'd127, 14'sd8191);
      send_msg(KIND_PRESSURE, 4'd5, 7'd0, 7'd127, 14'sd0);
      send_msg(KIND_NOTE_ON, 4'd4, 7'd70, 7'd90, 14'sd0);
      send_msg(KIND_SPARE, 4'd5, 7'd70, 7'd90, 14'sd0);

      random_phase(32, 59, 5'd0, 145);
      random_phase(59, 32, 5'd15, 145);
      random_phase(0, 0, ALL_CHANNELS, 145);

      wait_idle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
